// ----- design/mie_pkg.sv -----
`timescale 1ns / 1ps

package mie_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

endpackage

// ----- design/mie_if.sv -----
`timescale 1ns / 1ps

interface mie_in_if #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface mie_out_if #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] inverse;
  logic                 not_invertible;

  modport source (output valid, output inverse, output not_invertible, input ready);
  modport sink (input valid, input inverse, input not_invertible, output ready);
endinterface

interface mie_cfg_if #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/modular_inverse_ext_euclid_top.sv -----
`timescale 1ns / 1ps

// Modular inverse of value modulo the configured modulus (reset 1000000007) by the extended
// Euclidean algorithm. Each word on req yields one word on rsp: inverse is the Bezout
// coefficient of value reduced into 0..modulus-1, and not_invertible is set when the gcd is
// not 1 (value 0 gives 0 with the flag set unless the modulus is 1; modulus 0 gives 0, flag
// clear only for value 1).
// One word is worked on at a time and req is not ready meanwhile. Each Euclid step runs on one
// shared restoring divider that makes one quotient bit per cycle while it builds the product
// of quotient and coefficient, then passes through an update state (ST_UPD). A zero value or
// zero modulus skips the divider and goes straight to ST_FIN. The modulus may be written on cfg
// at any time the block is idle; cfg is always ready.
module modular_inverse_ext_euclid_top #(
  parameter int WORD_BITS = mie_pkg::WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mie_in_if.sink    req,
  mie_out_if.source rsp,
  mie_cfg_if.sink   cfg
);

  localparam int TW = WORD_BITS + 3;
  localparam int CW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] MOD_RST = mie_pkg::MODULUS_RESET[WORD_BITS-1:0];
  localparam logic [CW-1:0] CNT_TOP = CW'(WORD_BITS - 1);

  mie_pkg::state_t state, state_next;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] m_reg;
  logic                 m_zero;
  logic [WORD_BITS-1:0] prev_r, cur_r, dvd, rem;
  logic signed [TW-1:0] prev_t, cur_t, prod;
  logic [CW-1:0]        cnt;

  logic                 out_valid;
  logic [WORD_BITS-1:0] out_inverse;
  logic                 out_flag;

  logic                 accept;
  logic                 load_out;
  logic [WORD_BITS:0]   trial;
  logic                 ge;
  logic [WORD_BITS:0]   diff;
  logic signed [TW-1:0] new_t;
  logic signed [TW-1:0] neg_t;
  logic [TW-1:0]        m_ext;
  logic [WORD_BITS-1:0] mag;
  logic [WORD_BITS-1:0] norm;

  assign req.ready = (state == mie_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid          = out_valid;
  assign rsp.inverse        = out_inverse;
  assign rsp.not_invertible = out_flag;

  assign trial = {rem, dvd[WORD_BITS-1]};
  assign diff  = trial - {1'b0, cur_r};
  assign ge    = (trial >= {1'b0, cur_r});
  assign new_t = prev_t - prod;
  assign neg_t = -prev_t;
  assign m_ext = TW'(m_reg);

  always_comb begin
    mag  = '0;
    norm = '0;
    if (m_zero) begin
      norm = '0;
    end else if (!prev_t[TW-1]) begin
      mag  = (prev_t == $signed(m_ext)) ? '0 : prev_t[WORD_BITS-1:0];
      norm = mag;
    end else begin
      mag  = (neg_t == $signed(m_ext)) ? '0 : neg_t[WORD_BITS-1:0];
      norm = (mag == '0) ? '0 : m_reg - mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      mie_pkg::ST_IDLE: begin
        if (accept) begin
          if (modulus == '0 || req.value == '0) begin
            state_next = mie_pkg::ST_FIN;
          end else begin
            state_next = mie_pkg::ST_DIV;
          end
        end
      end
      mie_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = mie_pkg::ST_UPD;
        end
      end
      mie_pkg::ST_UPD: begin
        state_next = (rem == '0) ? mie_pkg::ST_FIN : mie_pkg::ST_DIV;
      end
      mie_pkg::ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = mie_pkg::ST_IDLE;
        end
      end
      default: state_next = mie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RST;
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inverse <= norm;
      out_flag    <= (prev_r != WORD_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mie_pkg::ST_IDLE: begin
        if (accept) begin
          m_reg  <= modulus;
          m_zero <= (modulus == '0);
          prev_r <= (modulus == '0) ? req.value : modulus;
          cur_r  <= req.value;
          dvd    <= modulus;
          rem    <= '0;
          prev_t <= '0;
          cur_t  <= TW'(1);
          prod   <= '0;
          cnt    <= CNT_TOP;
        end
      end
      mie_pkg::ST_DIV: begin
        rem  <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        dvd  <= {dvd[WORD_BITS-2:0], 1'b0};
        prod <= (prod <<< 1) + (ge ? cur_t : '0);
        cnt  <= cnt - CW'(1);
      end
      mie_pkg::ST_UPD: begin
        prev_r <= cur_r;
        cur_r  <= rem;
        prev_t <= cur_t;
        cur_t  <= new_t;
        dvd    <= cur_r;
        rem    <= '0;
        prod   <= '0;
        cnt    <= CNT_TOP;
      end
      mie_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sim/modular_inverse_ext_euclid_top_tb.sv -----
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_top_tb;

  localparam int W = mie_pkg::WORD_BITS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         not_invertible;
  } inv_word_t;

  logic clk;
  logic rst;

  mie_in_if  #(.WORD_BITS(W)) req_if ();
  mie_out_if #(.WORD_BITS(W)) rsp_if ();
  mie_cfg_if #(.WORD_BITS(W)) cfg_if ();

  modular_inverse_ext_euclid_top #(.WORD_BITS(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  inv_word_t    expected_inverses[$];
  logic [W-1:0] cur_modulus;
  bit           idling;
  int           rsp_hold;
  int           rsp_stall;
  int           errors;
  longint       cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [W-1:0] reduce_coef(logic [63:0] coef, logic [63:0] m);
    logic [63:0] mag;
    logic [63:0] rem;
    if (!coef[63]) return W'(coef % m);
    mag = ~coef + 64'd1;
    rem = mag % m;
    return (rem == 64'd0) ? '0 : W'(m - rem);
  endfunction

  function automatic inv_word_t calc_inverse(logic [W-1:0] value, logic [W-1:0] modulus);
    logic [63:0] pr, cr, pt, ct, q, nr, nt;
    inv_word_t   r;
    if (modulus == '0) begin
      r.inverse = '0;
      r.not_invertible = (value != W'(1));
      return r;
    end
    pr = 64'(modulus);
    cr = 64'(value);
    pt = 64'd0;
    ct = 64'd1;
    while (cr != 64'd0) begin
      q  = pr / cr;
      nr = pr - q * cr;
      nt = pt - q * ct;
      pr = cr;
      cr = nr;
      pt = ct;
      ct = nt;
    end
    r.inverse = reduce_coef(pt, 64'(modulus));
    r.not_invertible = (pr != 64'd1);
    return r;
  endfunction

  function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = W'($urandom);
      4, 5, 6:    v = (m == '0) ? W'($urandom) : W'($urandom) % m;
      7:          v = W'($urandom_range(0, 20));
      8:          v = m - W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = W'(1);
          2:       v = '1;
          default: v = m * W'($urandom_range(1, 3));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_value(logic [W-1:0] v);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= v;
    do @(posedge clk); while (!req_if.ready);
    expected_inverses.push_back(calc_inverse(v, cur_modulus));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
  endtask

  task automatic set_modulus(logic [W-1:0] m);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_modulus = m;
  endtask

  task automatic run_random_phase(logic [W-1:0] m, int n);
    set_modulus(m);
    repeat (n) send_value(pick_value(m));
  endtask

  task automatic test_reset_modulus();
    send_value('0);
    send_value(W'(1));
    send_value(W'(2));
    send_value('1);
    send_value(W'(1000000006));
    send_value(W'(1000000007));
    send_value(W'(1000000008));
  endtask

  task automatic test_edge_moduli();
    set_modulus('1);
    send_value('0);
    send_value(W'(3));
    send_value(W'(65537));
    send_value('1);
    send_value(W'(32'hFFFF_FFFE));
    send_value(W'(32'h8000_0000));
    set_modulus(W'(2));
    send_value(W'(2));
    send_value(W'(3));
    send_value(W'(32'hFFFF_FFFE));
    set_modulus(W'(1));
    send_value('0);
    send_value('1);
    set_modulus('0);
    send_value('0);
    send_value(W'(1));
    send_value('1);
  endtask

  task automatic test_longest_chain();
    set_modulus(W'(32'd2971215073));
    send_value(W'(32'd1836311903));
    send_value('0);
  endtask

  task automatic test_random_traffic();
    run_random_phase(W'($urandom), 60);
    run_random_phase(W'($urandom_range(2, 64)), 60);
    run_random_phase(W'(1) << $urandom_range(1, W - 1), 60);
    run_random_phase('1, 60);
    run_random_phase(W'($urandom) | W'(1), 60);
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    set_modulus(mie_pkg::MODULUS_RESET[W-1:0]);
    rsp_hold = 3000;
    repeat (6) send_value(W'($urandom));
    wait_drained();
  endtask

  task automatic test_quiet_tail();
    idling = 1'b0;
    run_random_phase(W'($urandom), 60);
  endtask

  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold = rsp_hold - 1;
    end else if (rsp_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = rsp_stall - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = $urandom_range(0, 11);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    inv_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected word inverse=%0d not_invertible=%0b", $time,
                 rsp_if.inverse, rsp_if.not_invertible);
        errors++;
      end else begin
        want = expected_inverses.pop_front();
        if (rsp_if.inverse !== want.inverse) begin
          $display("%0t: inverse expected %0d actual %0d", $time, want.inverse,
                   rsp_if.inverse);
          errors++;
        end
        if (rsp_if.not_invertible !== want.not_invertible) begin
          $display("%0t: not_invertible expected %0b actual %0b", $time,
                   want.not_invertible, rsp_if.not_invertible);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** modular_inverse_ext_euclid_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    idling = 1'b1;
    rsp_hold = 0;
    rsp_stall = 0;
    errors = 0;
    cycles = 0;
    cur_modulus = mie_pkg::MODULUS_RESET[W-1:0];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_modulus();
    test_edge_moduli();
    test_longest_chain();
    test_random_traffic();
    test_backpressure();
    test_quiet_tail();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** modular_inverse_ext_euclid_top: PASSED **");
    end else begin
      $display("** modular_inverse_ext_euclid_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mie_pkg.sv
design/mie_if.sv
design/modular_inverse_ext_euclid_top.sv
sim/modular_inverse_ext_euclid_top_tb.sv
